### design/resolver_angle_to_sine_cosine_dac_macros.svh
// ----------------------------------------------------------------------------
// Resolver DAC assertion macros
// Clocked implication checks, compiled out when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef RESOLVER_ANGLE_TO_SINE_COSINE_DAC_MACROS_SVH
`define RESOLVER_ANGLE_TO_SINE_COSINE_DAC_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define RSCD_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle implication check failed");
// next-cycle implication
`define RSCD_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");
`else
`define RSCD_ASSERT_IMP(label, clk, rstn, ante, cons)
`define RSCD_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif

`endif

### design/rscd_pkg.sv
// ----------------------------------------------------------------------------
// Resolver DAC package
// Shared constants, series tables, sequencer and multiplier types.
// ----------------------------------------------------------------------------
package rscd_pkg;

    localparam int CHANNEL_COUNT = 3;
    localparam int CH_IDX_W      = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

    localparam int ANGLE_W = 24;
    localparam int CODE_W  = 12;

    // command kinds
    localparam logic CMD_RESOLVER = 1'b0;

    // angle units of 1/64 degree
    localparam logic [14:0] FULL_TURN    = 15'd23040;
    localparam logic [14:0] QUARTER_TURN = 15'd5760;
    localparam logic [14:0] HALF_TURN    = 15'd11520;
    localparam logic [14:0] THREE_QUART  = 15'd17280;

    // floor(2^32 / 23040)
    localparam logic [31:0] TURN_RECIP   = 32'd186413;
    // pi/11520 in Q30
    localparam logic [31:0] RAD_PER_UNIT = 32'd292818;
    localparam logic [30:0] Q30_ONE      = 31'h4000_0000;

    localparam logic [11:0] CODE_ZERO = 12'd2048;

    // series term positions: sine terms first, then cosine
    localparam logic [3:0] TERM_SINE_LAST = 4'd4;
    localparam logic [3:0] TERM_LAST      = 4'd10;

    typedef enum logic [16:0] {
        ST_IDLE     = 17'h00001,
        ST_RED_MUL  = 17'h00002,
        ST_RED_BACK = 17'h00004,
        ST_RED_FIX  = 17'h00008,
        ST_CMP      = 17'h00010,
        ST_QUAD     = 17'h00020,
        ST_X_MUL    = 17'h00040,
        ST_X_SQ     = 17'h00080,
        ST_X2_CAP   = 17'h00100,
        ST_H_MUL    = 17'h00200,
        ST_H_REC    = 17'h00400,
        ST_H_BACK   = 17'h00800,
        ST_H_FIX    = 17'h01000,
        ST_S_FIN    = 17'h02000,
        ST_S_CLAMP  = 17'h04000,
        ST_CODE_MAG = 17'h08000,
        ST_CODE_OUT = 17'h10000
    } state_t;

    typedef enum logic [1:0] {
        QUAD_I   = 2'd0,
        QUAD_II  = 2'd1,
        QUAD_III = 2'd2,
        QUAD_IV  = 2'd3
    } quad_t;

    // operand pair for the shared multiplier
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
    } mul_req_t;

    // Horner divisor for each term position
    function automatic logic [7:0] series_divisor(input logic [3:0] term);
        logic [7:0] k;
        case (term)
            4'd0:    k = 8'd110;
            4'd1:    k = 8'd72;
            4'd2:    k = 8'd42;
            4'd3:    k = 8'd20;
            4'd4:    k = 8'd6;
            4'd5:    k = 8'd132;
            4'd6:    k = 8'd90;
            4'd7:    k = 8'd56;
            4'd8:    k = 8'd30;
            4'd9:    k = 8'd12;
            4'd10:   k = 8'd2;
            default: k = 8'd1;
        endcase
        return k;
    endfunction

    // floor(2^32 / divisor); estimate is low by at most one
    function automatic logic [31:0] series_recip(input logic [3:0] term);
        logic [31:0] m;
        case (term)
            4'd0:    m = 32'd39045157;
            4'd1:    m = 32'd59652323;
            4'd2:    m = 32'd102261126;
            4'd3:    m = 32'd214748364;
            4'd4:    m = 32'd715827882;
            4'd5:    m = 32'd32537631;
            4'd6:    m = 32'd47721858;
            4'd7:    m = 32'd76695844;
            4'd8:    m = 32'd143165576;
            4'd9:    m = 32'd357913941;
            4'd10:   m = 32'd2147483648;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

### design/rscd_mul.sv
// ----------------------------------------------------------------------------
// Resolver DAC shared multiplier
// 32 x 32 unsigned multiply, product registered.
// ----------------------------------------------------------------------------
module rscd_mul (
    input  logic               aclk,
    input  rscd_pkg::mul_req_t req,
    output logic [63:0]        prod
);

    logic [63:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= {32'd0, req.a} * {32'd0, req.b};
    end

    assign prod = prod_reg;

endmodule

### design/resolver_angle_to_sine_cosine_dac.sv
// ----------------------------------------------------------------------------
// Resolver angle to sine/cosine DAC code generator
// Turns resolver angle commands into offset-binary converter codes and frames.
// ----------------------------------------------------------------------------
// Usage
//   s_ channel: one angle command per transaction. s_tuser is the command
//   kind (0 = resolver update), s_tdata holds channel and signed angle.
//   Other kinds and channels at or above the channel count are dropped in
//   the cycle they are taken, with no result.
//   m_ channel: one result per changed angle: channel, sine and cosine codes
//   and the three converter frame bytes.
//   Sequence: one shared 32x32 multiplier steps through the reduction
//   and eleven Horner terms, each term as multiply, reciprocal,
//   back-multiply and fix steps; the next command is taken only once
//   the sequencer is back in idle. An unchanged angle ends after the
//   compare, a dropped command as soon as it is taken.
//   Reset: all stored channel angles read zero, so a zero angle (or any
//   whole turn) gives nothing until the channel has held another angle.
//   Stall: the result sits in an output register; the sequencer takes the
//   next command meanwhile and only waits at its final step for the slot.
// ----------------------------------------------------------------------------
`include "resolver_angle_to_sine_cosine_dac_macros.svh"

module resolver_angle_to_sine_cosine_dac (
    input  logic        aclk,
    input  logic        aresetn,
    // command in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [2:0] channel, [26:3] angle, [31:27] zero
    input  logic        s_tuser,   // [0] command
    // result out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // [2:0] out_channel, [14:3] sine_code,
                                   // [26:15] cosine_code, [34:27] frame_first,
                                   // [42:35] frame_second, [50:43] frame_third,
                                   // [55:51] zero
);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    rscd_pkg::state_t state_reg, state_next;
    logic [3:0]       term_reg, term_next;
    logic             out_valid_reg, out_valid_next;

    logic [2:0]       chan_reg, chan_next;
    logic             neg_reg, neg_next;
    logic [23:0]      abs_reg, abs_next;
    logic [14:0]      mag_reg, mag_next;
    logic [14:0]      u_reg, u_next;
    rscd_pkg::quad_t  quad_reg, quad_next;
    logic [12:0]      r_reg, r_next;
    logic [30:0]      x_reg, x_next;
    logic [31:0]      x2_reg, x2_next;
    logic [30:0]      t_reg, t_next;
    logic [31:0]      p_reg, p_next;
    logic [31:0]      qe_reg, qe_next;
    logic [30:0]      s_reg, s_next;
    logic [40:0]      vs_reg, vs_next;
    logic [40:0]      vc_reg, vc_next;
    logic             sneg_reg, sneg_next;
    logic             cneg_reg, cneg_next;

    logic [2:0]       och_reg, och_next;
    logic [11:0]      osin_reg, osin_next;
    logic [11:0]      ocos_reg, ocos_next;

    logic [15:0]      last_angle_reg [rscd_pkg::CHANNEL_COUNT];

    // ------------------------------------------------------------------
    // Combinational helpers
    // ------------------------------------------------------------------
    rscd_pkg::mul_req_t mul_req;
    logic [63:0]        mul_prod;

    logic        item_ok;
    logic [2:0]  in_chan;
    logic [23:0] in_angle;
    logic [24:0] red_rem;
    logic [24:0] red_sub;
    logic [15:0] stored_c;
    logic        last_wr;
    logic [31:0] h_rem;
    logic [31:0] h_quo;
    logic [31:0] s_prod;
    logic [30:0] sm_c, cm_c;
    logic [41:0] vs_full, vc_full;
    logic [11:0] s_ceil, c_ceil;
    logic        out_load;

    assign in_chan  = s_tdata[2:0];
    assign in_angle = s_tdata[26:3];
    assign item_ok  = (s_tuser == rscd_pkg::CMD_RESOLVER) &&
                      ({1'b0, in_chan} < 4'(rscd_pkg::CHANNEL_COUNT));

    assign s_tready = (state_reg == rscd_pkg::ST_IDLE);

    // shared multiplier
    rscd_mul u_mul (
        .aclk (aclk),
        .req  (mul_req),
        .prod (mul_prod)
    );

    // operands come straight from registers, constants or slices of the last product
    always_comb begin
        mul_req.a = 32'd0;
        mul_req.b = 32'd0;
        case (state_reg)
            rscd_pkg::ST_RED_MUL: begin
                mul_req.a = {8'd0, abs_reg};
                mul_req.b = rscd_pkg::TURN_RECIP;
            end
            rscd_pkg::ST_RED_BACK: begin
                mul_req.a = mul_prod[63:32];
                mul_req.b = {17'd0, rscd_pkg::FULL_TURN};
            end
            rscd_pkg::ST_X_MUL: begin
                mul_req.a = {19'd0, r_reg};
                mul_req.b = rscd_pkg::RAD_PER_UNIT;
            end
            rscd_pkg::ST_X_SQ: begin
                mul_req.a = mul_prod[31:0];
                mul_req.b = mul_prod[31:0];
            end
            rscd_pkg::ST_H_MUL: begin
                mul_req.a = x2_reg;
                mul_req.b = {1'b0, t_reg};
            end
            rscd_pkg::ST_H_REC: begin
                mul_req.a = mul_prod[61:30];
                mul_req.b = rscd_pkg::series_recip(term_reg);
            end
            rscd_pkg::ST_H_BACK: begin
                mul_req.a = mul_prod[63:32];
                mul_req.b = {24'd0, rscd_pkg::series_divisor(term_reg)};
            end
            rscd_pkg::ST_S_FIN: begin
                mul_req.a = {1'b0, x_reg};
                mul_req.b = {1'b0, t_reg};
            end
            default: begin
                mul_req.a = 32'd0;
                mul_req.b = 32'd0;
            end
        endcase
    end

    // remainder of the turn reduction, one correction step
    assign red_rem = {1'b0, abs_reg} - mul_prod[24:0];
    assign red_sub = red_rem - {10'd0, rscd_pkg::FULL_TURN};

    // signed reduced angle as stored per channel
    assign stored_c = neg_reg ? (16'd0 - {1'b0, mag_reg}) : {1'b0, mag_reg};

    // Horner step: quotient estimate corrected, then 1 - quotient
    assign h_rem = p_reg - mul_prod[31:0];
    assign h_quo = qe_reg +
                   ((h_rem >= {24'd0, rscd_pkg::series_divisor(term_reg)}) ? 32'd1 : 32'd0);

    assign s_prod = mul_prod[61:30];

    // quadrant rotation
    always_comb begin
        case (quad_reg)
            rscd_pkg::QUAD_I: begin
                sm_c = s_reg; cm_c = t_reg;
                sneg_next = 1'b0; cneg_next = 1'b0;
            end
            rscd_pkg::QUAD_II: begin
                sm_c = t_reg; cm_c = s_reg;
                sneg_next = 1'b0; cneg_next = 1'b1;
            end
            rscd_pkg::QUAD_III: begin
                sm_c = s_reg; cm_c = t_reg;
                sneg_next = 1'b1; cneg_next = 1'b1;
            end
            default: begin
                sm_c = t_reg; cm_c = s_reg;
                sneg_next = 1'b1; cneg_next = 1'b0;
            end
        endcase
    end

    // 2047 * magnitude
    assign vs_full = {sm_c, 11'd0} - {11'd0, sm_c};
    assign vc_full = {cm_c, 11'd0} - {11'd0, cm_c};

    // rounded up for negative values
    assign s_ceil = {1'b0, vs_reg[40:30]} + {11'd0, (|vs_reg[29:0])};
    assign c_ceil = {1'b0, vc_reg[40:30]} + {11'd0, (|vc_reg[29:0])};

    assign osin_next = sneg_reg ? (rscd_pkg::CODE_ZERO - s_ceil)
                                : (rscd_pkg::CODE_ZERO + {1'b0, vs_reg[40:30]});
    assign ocos_next = cneg_reg ? (rscd_pkg::CODE_ZERO - c_ceil)
                                : (rscd_pkg::CODE_ZERO + {1'b0, vc_reg[40:30]});
    assign och_next  = chan_reg;

    assign out_load = (state_reg == rscd_pkg::ST_CODE_OUT) && (!out_valid_reg || m_tready);

    always_comb begin
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        term_next  = term_reg;
        chan_next  = chan_reg;
        neg_next   = neg_reg;
        abs_next   = abs_reg;
        mag_next   = mag_reg;
        u_next     = u_reg;
        quad_next  = quad_reg;
        r_next     = r_reg;
        x_next     = x_reg;
        x2_next    = x2_reg;
        t_next     = t_reg;
        p_next     = p_reg;
        qe_next    = qe_reg;
        s_next     = s_reg;
        vs_next    = vs_reg;
        vc_next    = vc_reg;
        last_wr    = 1'b0;

        case (state_reg)
            rscd_pkg::ST_IDLE: begin
                chan_next = in_chan;
                neg_next  = in_angle[23];
                abs_next  = in_angle[23] ? (~in_angle + 24'd1) : in_angle;
                if (s_tvalid && item_ok) begin
                    state_next = rscd_pkg::ST_RED_MUL;
                end
            end
            rscd_pkg::ST_RED_MUL: begin
                state_next = rscd_pkg::ST_RED_BACK;
            end
            rscd_pkg::ST_RED_BACK: begin
                state_next = rscd_pkg::ST_RED_FIX;
            end
            rscd_pkg::ST_RED_FIX: begin
                mag_next   = (red_rem >= {10'd0, rscd_pkg::FULL_TURN}) ? red_sub[14:0]
                                                                       : red_rem[14:0];
                state_next = rscd_pkg::ST_CMP;
            end
            rscd_pkg::ST_CMP: begin
                u_next = (neg_reg && (mag_reg != 15'd0)) ? (rscd_pkg::FULL_TURN - mag_reg)
                                                         : mag_reg;
                if (stored_c == last_angle_reg[chan_reg[rscd_pkg::CH_IDX_W-1:0]]) begin
                    state_next = rscd_pkg::ST_IDLE;
                end else begin
                    last_wr    = 1'b1;
                    state_next = rscd_pkg::ST_QUAD;
                end
            end
            rscd_pkg::ST_QUAD: begin
                if (u_reg >= rscd_pkg::THREE_QUART) begin
                    quad_next = rscd_pkg::QUAD_IV;
                    r_next    = 13'(u_reg - rscd_pkg::THREE_QUART);
                end else if (u_reg >= rscd_pkg::HALF_TURN) begin
                    quad_next = rscd_pkg::QUAD_III;
                    r_next    = 13'(u_reg - rscd_pkg::HALF_TURN);
                end else if (u_reg >= rscd_pkg::QUARTER_TURN) begin
                    quad_next = rscd_pkg::QUAD_II;
                    r_next    = 13'(u_reg - rscd_pkg::QUARTER_TURN);
                end else begin
                    quad_next = rscd_pkg::QUAD_I;
                    r_next    = u_reg[12:0];
                end
                state_next = rscd_pkg::ST_X_MUL;
            end
            rscd_pkg::ST_X_MUL: begin
                state_next = rscd_pkg::ST_X_SQ;
            end
            rscd_pkg::ST_X_SQ: begin
                x_next     = mul_prod[30:0];
                state_next = rscd_pkg::ST_X2_CAP;
            end
            rscd_pkg::ST_X2_CAP: begin
                x2_next    = mul_prod[61:30];
                t_next     = rscd_pkg::Q30_ONE;
                term_next  = 4'd0;
                state_next = rscd_pkg::ST_H_MUL;
            end
            rscd_pkg::ST_H_MUL: begin
                state_next = rscd_pkg::ST_H_REC;
            end
            rscd_pkg::ST_H_REC: begin
                p_next     = mul_prod[61:30];
                state_next = rscd_pkg::ST_H_BACK;
            end
            rscd_pkg::ST_H_BACK: begin
                qe_next    = mul_prod[63:32];
                state_next = rscd_pkg::ST_H_FIX;
            end
            rscd_pkg::ST_H_FIX: begin
                t_next    = (h_quo >= {1'b0, rscd_pkg::Q30_ONE}) ? 31'd0
                                                                 : 31'({1'b0, rscd_pkg::Q30_ONE} - h_quo);
                term_next = term_reg + 4'd1;
                if (term_reg == rscd_pkg::TERM_SINE_LAST) begin
                    state_next = rscd_pkg::ST_S_FIN;
                end else if (term_reg == rscd_pkg::TERM_LAST) begin
                    state_next = rscd_pkg::ST_CODE_MAG;
                end else begin
                    state_next = rscd_pkg::ST_H_MUL;
                end
            end
            rscd_pkg::ST_S_FIN: begin
                state_next = rscd_pkg::ST_S_CLAMP;
            end
            rscd_pkg::ST_S_CLAMP: begin
                s_next     = (s_prod > {1'b0, rscd_pkg::Q30_ONE}) ? rscd_pkg::Q30_ONE
                                                                  : s_prod[30:0];
                t_next     = rscd_pkg::Q30_ONE;
                state_next = rscd_pkg::ST_H_MUL;
            end
            rscd_pkg::ST_CODE_MAG: begin
                vs_next    = vs_full[40:0];
                vc_next    = vc_full[40:0];
                state_next = rscd_pkg::ST_CODE_OUT;
            end
            rscd_pkg::ST_CODE_OUT: begin
                if (out_load) begin
                    state_next = rscd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rscd_pkg::ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= rscd_pkg::ST_IDLE;
            term_reg      <= 4'd0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            term_reg      <= term_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        chan_reg <= chan_next;
        neg_reg  <= neg_next;
        abs_reg  <= abs_next;
        mag_reg  <= mag_next;
        u_reg    <= u_next;
        quad_reg <= quad_next;
        r_reg    <= r_next;
        x_reg    <= x_next;
        x2_reg   <= x2_next;
        t_reg    <= t_next;
        p_reg    <= p_next;
        qe_reg   <= qe_next;
        s_reg    <= s_next;
        vs_reg   <= vs_next;
        vc_reg   <= vc_next;
        if (state_reg == rscd_pkg::ST_CODE_MAG) begin
            sneg_reg <= sneg_next;
            cneg_reg <= cneg_next;
        end
        if (out_load) begin
            och_reg  <= och_next;
            osin_reg <= osin_next;
            ocos_reg <= ocos_next;
        end
    end

    // per-channel angle store, zero after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < rscd_pkg::CHANNEL_COUNT; i++) begin
                last_angle_reg[i] <= 16'd0;
            end
        end else if (last_wr) begin
            last_angle_reg[chan_reg[rscd_pkg::CH_IDX_W-1:0]] <= stored_c;
        end
    end

    // ------------------------------------------------------------------
    // Result channel: codes plus the three converter frame bytes
    // ------------------------------------------------------------------
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0,
                       osin_reg[7:0],
                       ocos_reg[3:0], osin_reg[11:8],
                       ocos_reg[11:4],
                       ocos_reg,
                       osin_reg,
                       och_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `RSCD_ASSERT_IMP(a_code_range, aclk, aresetn, m_tvalid, (m_tdata[14:3] != 12'd0) && (m_tdata[26:15] != 12'd0))
    `RSCD_ASSERT_IMP(a_term_bound, aclk, aresetn, state_reg == rscd_pkg::ST_H_FIX, term_reg <= rscd_pkg::TERM_LAST)
    `RSCD_ASSERT_NXT(a_start, aclk, aresetn, s_tvalid && s_tready && item_ok, state_reg == rscd_pkg::ST_RED_MUL)
    `RSCD_ASSERT_IMP(a_t_bound, aclk, aresetn, state_reg == rscd_pkg::ST_H_MUL, t_reg <= rscd_pkg::Q30_ONE)

endmodule
